[design/vqte_pkg.sv]
// Shared constants, types and a helper function for the virtqueue transaction engine.
`default_nettype none

package vqte_pkg;

	// Queue geometry.
	localparam int QUEUE_SIZE    = 64;
	localparam int DESCS_PER_TXN = 4;
	localparam int MAX_SLOTS     = 16;

	// Usable slots: the least of the slot table size, the queue capacity and the
	// 6-bit descriptor index space.
	localparam int SLOTS_BY_QUEUE = QUEUE_SIZE / DESCS_PER_TXN;
	localparam int SLOTS_BY_INDEX = 64 / DESCS_PER_TXN;
	localparam int SLOTS_MIN_QI   = (SLOTS_BY_INDEX < SLOTS_BY_QUEUE) ?
		SLOTS_BY_INDEX : SLOTS_BY_QUEUE;
	localparam int SLOT_TOTAL     = (SLOTS_MIN_QI > MAX_SLOTS) ? MAX_SLOTS : SLOTS_MIN_QI;

	localparam logic [6:0] DPT7      = 7'(DESCS_PER_TXN);
	localparam logic [4:0] SLOT_LIM5 = 5'(SLOT_TOTAL);

	// Result kinds.
	typedef enum logic [1:0] {
		RK_DESC   = 2'd0,
		RK_POST   = 2'd1,
		RK_COMP   = 2'd2,
		RK_NOSLOT = 2'd3
	} rkind_t;

	// Descriptor flag bits.
	localparam logic [1:0] FL_NONE  = 2'b00;
	localparam logic [1:0] FL_NEXT  = 2'b01;
	localparam logic [1:0] FL_WRITE = 2'b10;

	// Completion fault codes.
	typedef enum logic [1:0] {
		FT_NONE    = 2'd0,
		FT_OVERLEN = 2'd1,
		FT_NOTBUSY = 2'd2
	} fault_t;

	// Controller states.
	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic emit;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic last;
	} sts_t;

	// Quotient of a descriptor index by the descriptors per transaction, mod 16.
	// Each compare is against a constant, so this reduces to a small table.
	function automatic logic [3:0] slot_of(input logic [5:0] id);
		logic [3:0] q;
		q = '0;
		for (int k = 1; k < MAX_SLOTS; k++) begin
			if (int'(id) >= k * DESCS_PER_TXN) begin
				q = 4'(k);
			end
		end
		return q;
	endfunction

endpackage

`default_nettype wire

[design/vqte_ctrl.sv]
// Controller state machine for the virtqueue transaction engine.
`default_nettype none

module vqte_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  wire logic           out_stall,
	output vqte_pkg::cmd_t      cmd,
	input  wire vqte_pkg::sts_t sts
);

	vqte_pkg::state_t state_q;
	vqte_pkg::state_t state_d;
	logic             out_valid_q;
	logic             out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vqte_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_stall  = 1'b1;
		out_ready = !out_valid_q || !out_stall;
		unique case (state_q)
			vqte_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = vqte_pkg::ST_EMIT;
				end
			end
			vqte_pkg::ST_EMIT: begin
				if (out_ready) begin
					cmd.emit = 1'b1;
					// The final result frees the input side in the same cycle.
					if (sts.last) begin
						in_stall = 1'b0;
						state_d  = in_valid ? vqte_pkg::ST_EMIT : vqte_pkg::ST_IDLE;
					end
				end
			end
		endcase
		cmd.load = in_valid && !in_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

[design/vqte_dp.sv]
// Datapath of the virtqueue transaction engine: slot table, item registers, result register.
`default_nettype none

module vqte_dp (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire vqte_pkg::cmd_t cmd,
	output vqte_pkg::sts_t      sts,
	input  wire logic           kind,
	input  wire logic [31:0]    req_addr,
	input  wire logic [31:0]    req_len,
	input  wire logic [31:0]    out_addr,
	input  wire logic [31:0]    out_length,
	input  wire logic [31:0]    resp_addr,
	input  wire logic [31:0]    resp_len,
	input  wire logic [31:0]    in_addr,
	input  wire logic [31:0]    in_length,
	input  wire logic [5:0]     used_id,
	input  wire logic [31:0]    used_len,
	output logic [1:0]          result_kind,
	output logic [5:0]          desc_index,
	output logic [31:0]         buf_addr,
	output logic [31:0]         buf_len,
	output logic [1:0]          desc_flags,
	output logic [5:0]          next_index,
	output logic [15:0]         avail_index,
	output logic [3:0]          txn_slot,
	output logic [31:0]         got_resp_len,
	output logic [31:0]         got_in_len,
	output logic                last,
	output logic [1:0]          fault
);

	// Slot table and counters.
	logic [vqte_pkg::MAX_SLOTS-1:0] busy_q;
	logic [31:0]                    resp_cap_q [vqte_pkg::MAX_SLOTS];
	logic [31:0]                    in_cap_q   [vqte_pkg::MAX_SLOTS];
	logic [15:0]                    avail_q;

	// Item registers.
	logic        is_comp_q;
	logic        nofree_q;
	logic [2:0]  step_q;
	logic [2:0]  ndesc_q;
	logic        has_out_q;
	logic        has_in_q;
	logic [3:0]  slot_q;
	logic [5:0]  head_q;
	logic [15:0] aidx_q;
	logic [31:0] req_addr_q, req_len_q, out_addr_q, out_len_q;
	logic [31:0] resp_addr_q, resp_len_q, in_addr_q, in_len_q;
	logic        bad_q;
	logic [31:0] ulen_q;
	logic [31:0] capr_q;
	logic [31:0] cin_q;

	// Load-time combinational values.
	logic        found_d;
	logic [3:0]  slot_d;
	logic [6:0]  head7_d;
	logic [3:0]  cq_d;
	logic [6:0]  chead7_d;
	logic        bad_d;

	// Completion split, from the captured length and capacities.
	logic [32:0] diff;
	logic        lt;
	logic [31:0] rest;

	// Next result.
	logic [1:0]  r_kind;
	logic [5:0]  r_didx;
	logic [31:0] r_addr;
	logic [31:0] r_len;
	logic [1:0]  r_flags;
	logic [5:0]  r_next;
	logic [15:0] r_aidx;
	logic [3:0]  r_slot;
	logic [31:0] r_gresp;
	logic [31:0] r_gin;
	logic        r_last;
	logic [1:0]  r_fault;
	logic        over;
	logic [2:0]  resp_step;

	// Lowest free slot among the usable ones.
	always_comb begin
		found_d = 1'b0;
		slot_d  = '0;
		for (int i = vqte_pkg::SLOT_TOTAL - 1; i >= 0; i--) begin
			if (!busy_q[i]) begin
				found_d = 1'b1;
				slot_d  = 4'(i);
			end
		end
	end

	assign head7_d  = 7'({3'b000, slot_d} * vqte_pkg::DPT7);
	assign cq_d     = vqte_pkg::slot_of(used_id);
	assign chead7_d = 7'({3'b000, cq_d} * vqte_pkg::DPT7);
	assign bad_d    = (chead7_d != {1'b0, used_id}) ||
		({1'b0, cq_d} >= vqte_pkg::SLOT_LIM5) || !busy_q[cq_d];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= '0;
			avail_q   <= '0;
			step_q    <= '0;
			is_comp_q <= 1'b0;
			nofree_q  <= 1'b0;
		end else if (cmd.load) begin
			step_q    <= '0;
			is_comp_q <= kind;
			if (!kind) begin
				nofree_q <= !found_d;
				if (found_d) begin
					busy_q[slot_d] <= 1'b1;
					avail_q        <= avail_q + 16'd1;
				end
			end else begin
				nofree_q <= 1'b0;
				if (!bad_d) begin
					busy_q[cq_d] <= 1'b0;
				end
			end
		end else if (cmd.emit) begin
			step_q <= step_q + 3'd1;
		end
	end

	// Capacities are written at each successful submit.
	always_ff @(posedge clk) begin
		if (cmd.load && !kind && found_d) begin
			resp_cap_q[slot_d] <= resp_len;
			in_cap_q[slot_d]   <= in_length;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			slot_q      <= kind ? cq_d : slot_d;
			head_q      <= head7_d[5:0];
			aidx_q      <= avail_q;
			has_out_q   <= (out_length != '0);
			has_in_q    <= (in_length != '0);
			ndesc_q     <= 3'd2 + {2'b00, (out_length != '0)} + {2'b00, (in_length != '0)};
			req_addr_q  <= req_addr;
			req_len_q   <= req_len;
			out_addr_q  <= out_addr;
			out_len_q   <= out_length;
			resp_addr_q <= resp_addr;
			resp_len_q  <= resp_len;
			in_addr_q   <= in_addr;
			in_len_q    <= in_length;
			bad_q       <= bad_d;
			ulen_q      <= used_len;
			capr_q      <= resp_cap_q[cq_d];
			cin_q       <= in_cap_q[cq_d];
		end
	end

	assign diff      = {1'b0, ulen_q} - {1'b0, capr_q};
	assign lt        = diff[32];
	assign rest      = diff[31:0];
	assign resp_step = has_out_q ? 3'd2 : 3'd1;
	assign over      = !lt && (rest > cin_q);

	always_comb begin
		r_kind  = vqte_pkg::RK_DESC;
		r_didx  = '0;
		r_addr  = '0;
		r_len   = '0;
		r_flags = vqte_pkg::FL_NONE;
		r_next  = '0;
		r_aidx  = '0;
		r_slot  = '0;
		r_gresp = '0;
		r_gin   = '0;
		r_last  = 1'b0;
		r_fault = vqte_pkg::FT_NONE;
		if (is_comp_q) begin
			r_kind = vqte_pkg::RK_COMP;
			r_slot = slot_q;
			r_last = 1'b1;
			if (bad_q) begin
				r_fault = vqte_pkg::FT_NOTBUSY;
			end else begin
				r_gresp = lt ? ulen_q : capr_q;
				r_gin   = lt ? '0 : (over ? cin_q : rest);
				r_fault = over ? vqte_pkg::FT_OVERLEN : vqte_pkg::FT_NONE;
			end
		end else if (nofree_q) begin
			r_kind = vqte_pkg::RK_NOSLOT;
			r_last = 1'b1;
		end else if (step_q == ndesc_q) begin
			r_kind = vqte_pkg::RK_POST;
			r_didx = head_q;
			r_aidx = aidx_q;
			r_slot = slot_q;
			r_last = 1'b1;
		end else begin
			r_kind = vqte_pkg::RK_DESC;
			r_didx = head_q + {3'b000, step_q};
			r_slot = slot_q;
			if (step_q == 3'd0) begin
				r_addr  = req_addr_q;
				r_len   = req_len_q;
				r_flags = vqte_pkg::FL_NEXT;
			end else if (has_out_q && step_q == 3'd1) begin
				r_addr  = out_addr_q;
				r_len   = out_len_q;
				r_flags = vqte_pkg::FL_NEXT;
			end else if (step_q == resp_step) begin
				r_addr  = resp_addr_q;
				r_len   = resp_len_q;
				r_flags = has_in_q ? (vqte_pkg::FL_WRITE | vqte_pkg::FL_NEXT) :
					vqte_pkg::FL_WRITE;
			end else begin
				r_addr  = in_addr_q;
				r_len   = in_len_q;
				r_flags = vqte_pkg::FL_WRITE;
			end
			if (step_q != ndesc_q - 3'd1) begin
				r_next = r_didx + 6'd1;
			end
		end
	end

	assign sts.last = r_last;

	// Output register: loads on each emitted result and holds while stalled.
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			result_kind  <= r_kind;
			desc_index   <= r_didx;
			buf_addr     <= r_addr;
			buf_len      <= r_len;
			desc_flags   <= r_flags;
			next_index   <= r_next;
			avail_index  <= r_aidx;
			txn_slot     <= r_slot;
			got_resp_len <= r_gresp;
			got_in_len   <= r_gin;
			last         <= r_last;
			fault        <= r_fault;
		end
	end

endmodule

`default_nettype wire

[design/virtqueue_txn_engine.sv]
// Top level of the virtqueue transaction engine: controller plus datapath.
`default_nettype none

// Channel   Handshake            Payload
// input     in_valid / in_stall  kind, buffer addresses and lengths, used_id, used_len
// output    out_valid/out_stall  result_kind ... fault, one result per transfer
//
// A submit gives two to four descriptor writes and one avail post, one result
// per cycle while the output does not stall; a completion or a no-slot result
// gives a single result. The output register loads one result a cycle unless stalled.
// The next input transfer is taken in the cycle the final result is loaded.
// Reset clears the busy bits, the avail index and the handshake state.
// A stall on the output holds the result register and, behind it, the sequence.

module virtqueue_txn_engine (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        kind,
	input  wire logic [31:0] req_addr,
	input  wire logic [31:0] req_len,
	input  wire logic [31:0] out_addr,
	input  wire logic [31:0] out_length,
	input  wire logic [31:0] resp_addr,
	input  wire logic [31:0] resp_len,
	input  wire logic [31:0] in_addr,
	input  wire logic [31:0] in_length,
	input  wire logic [5:0]  used_id,
	input  wire logic [31:0] used_len,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       result_kind,
	output logic [5:0]       desc_index,
	output logic [31:0]      buf_addr,
	output logic [31:0]      buf_len,
	output logic [1:0]       desc_flags,
	output logic [5:0]       next_index,
	output logic [15:0]      avail_index,
	output logic [3:0]       txn_slot,
	output logic [31:0]      got_resp_len,
	output logic [31:0]      got_in_len,
	output logic             last,
	output logic [1:0]       fault
);

	// Load and emit commands go down; the last-result flag comes back.
	vqte_pkg::cmd_t cmd;
	vqte_pkg::sts_t sts;

	// The controller owns the handshakes and sequences each item's results.
	vqte_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	// The datapath holds the slot table, the captured item and the result register.
	vqte_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.kind         (kind),
		.req_addr     (req_addr),
		.req_len      (req_len),
		.out_addr     (out_addr),
		.out_length   (out_length),
		.resp_addr    (resp_addr),
		.resp_len     (resp_len),
		.in_addr      (in_addr),
		.in_length    (in_length),
		.used_id      (used_id),
		.used_len     (used_len),
		.result_kind  (result_kind),
		.desc_index   (desc_index),
		.buf_addr     (buf_addr),
		.buf_len      (buf_len),
		.desc_flags   (desc_flags),
		.next_index   (next_index),
		.avail_index  (avail_index),
		.txn_slot     (txn_slot),
		.got_resp_len (got_resp_len),
		.got_in_len   (got_in_len),
		.last         (last),
		.fault        (fault)
	);

endmodule

`default_nettype wire
